// ----- hdl/rhpc_pkg.sv -----
package rhpc_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 2048;

    // RTP fixed header and extension header lengths, in bytes
    localparam int FIXED_HDR  = 12;
    localparam int EXT_HDR    = 4;

    // packet length as carried between front and back
    localparam int LEN_W      = 16;
    // header length arithmetic: 12 + 60 + 4 + 4*65535 + 255 fits in 20 bits
    localparam int HDR_W      = 20;
    localparam int OUT_W      = 12;

    localparam int SUM_DEPTH  = 2;
    localparam int RES_DEPTH  = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_OVERSIZE = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [1:0]         version;
        logic               marker;
        logic [6:0]         payload_type;
        logic [15:0]        sequence_number;
        logic [31:0]        timestamp;
        logic [31:0]        ssrc;
        logic [3:0]         csrc_count;
        logic               extension_present;
        logic [15:0]        extension_type;
        logic [OUT_W-1:0]   payload_offset;
        logic [OUT_W-1:0]   payload_length;
    } result_t;

    // per-packet record handed from the byte front end to the checker
    typedef struct packed {
        logic               oversize;
        logic [LEN_W-1:0]   len;
        logic [7:0]         first_octet;
        logic [7:0]         second_octet;
        logic [15:0]        seq;
        logic [31:0]        tstamp;
        logic [31:0]        source;
        logic [15:0]        ext_type;
        logic [15:0]        ext_words;
        logic [7:0]         pad_byte;
    } summary_t;

endpackage

// ----- hdl/rhpc_queue.sv -----
module rhpc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/rhpc_front.sv -----
module rhpc_front #(
    parameter int MAX_PACKET_BYTES = rhpc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  rhpc_pkg::in_item_t in_item,
    output logic               sum_push,
    output rhpc_pkg::summary_t sum
);

    import rhpc_pkg::*;

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             oversize_reg, oversize_next;
    logic [7:0]       first_octet_reg, first_octet_next;
    logic [7:0]       second_octet_reg, second_octet_next;
    logic [15:0]      seq_reg, seq_next;
    logic [31:0]      tstamp_reg, tstamp_next;
    logic [31:0]      source_reg, source_next;
    logic [15:0]      ext_type_reg, ext_type_next;
    logic [15:0]      ext_words_reg, ext_words_next;
    logic [31:0]      pos;
    logic [31:0]      ext_at;
    logic [7:0]       b;

    assign b      = in_item.data_byte;
    assign pos    = 32'(byte_count_reg);
    // extension header follows the CSRC list
    assign ext_at = 32'(FIXED_HDR) + 32'({first_octet_reg[3:0], 2'b00});

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        oversize_next     = oversize_reg;
        first_octet_next  = first_octet_reg;
        second_octet_next = second_octet_reg;
        seq_next          = seq_reg;
        tstamp_next       = tstamp_reg;
        source_next       = source_reg;
        ext_type_next     = ext_type_reg;
        ext_words_next    = ext_words_reg;
        if (accept)
        begin
            if (byte_count_reg >= CNT_W'(MAX_PACKET_BYTES))
            begin
                oversize_next = 1'b1;
            end
            else
            begin
                byte_count_next = byte_count_reg + 1'b1;
                if (pos == 32'd0)
                begin
                    first_octet_next = b;
                end
                else if (pos == 32'd1)
                begin
                    second_octet_next = b;
                end
                else if (pos < 32'd4)
                begin
                    seq_next = {seq_reg[7:0], b};
                end
                else if (pos < 32'd8)
                begin
                    tstamp_next = {tstamp_reg[23:0], b};
                end
                else if (pos < 32'(FIXED_HDR))
                begin
                    source_next = {source_reg[23:0], b};
                end
                else if (pos == ext_at || pos == ext_at + 32'd1)
                begin
                    ext_type_next = {ext_type_reg[7:0], b};
                end
                else if (pos == ext_at + 32'd2 || pos == ext_at + 32'd3)
                begin
                    ext_words_next = {ext_words_reg[7:0], b};
                end
            end
        end
    end

    assign sum_push          = accept && in_item.last_byte;
    assign sum.oversize      = oversize_next;
    assign sum.len           = LEN_W'(byte_count_next);
    assign sum.first_octet   = first_octet_next;
    assign sum.second_octet  = second_octet_next;
    assign sum.seq           = seq_next;
    assign sum.tstamp        = tstamp_next;
    assign sum.source        = source_next;
    assign sum.ext_type      = ext_type_next;
    assign sum.ext_words     = ext_words_next;
    assign sum.pad_byte      = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            oversize_reg     <= 1'b0;
            first_octet_reg  <= '0;
            second_octet_reg <= '0;
            seq_reg          <= '0;
            tstamp_reg       <= '0;
            source_reg       <= '0;
            ext_type_reg     <= '0;
            ext_words_reg    <= '0;
        end
        else if (sum_push)
        begin
            // packet done: start clean for the next one
            byte_count_reg   <= '0;
            oversize_reg     <= 1'b0;
            first_octet_reg  <= '0;
            second_octet_reg <= '0;
            seq_reg          <= '0;
            tstamp_reg       <= '0;
            source_reg       <= '0;
            ext_type_reg     <= '0;
            ext_words_reg    <= '0;
        end
        else
        begin
            byte_count_reg   <= byte_count_next;
            oversize_reg     <= oversize_next;
            first_octet_reg  <= first_octet_next;
            second_octet_reg <= second_octet_next;
            seq_reg          <= seq_next;
            tstamp_reg       <= tstamp_next;
            source_reg       <= source_next;
            ext_type_reg     <= ext_type_next;
            ext_words_reg    <= ext_words_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(MAX_PACKET_BYTES))
        else $error("byte count past maximum");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        sum_push |=> (byte_count_reg == '0 && !oversize_reg && first_octet_reg == '0))
        else $error("packet state not cleared after last byte");
`endif

endmodule

// ----- hdl/rhpc_back.sv -----
module rhpc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rhpc_pkg::summary_t sum,
    input  logic               sum_empty,
    output logic               sum_pop,
    input  logic               res_full,
    output logic               res_push,
    output rhpc_pkg::result_t  res
);

    import rhpc_pkg::*;

    logic [HDR_W-1:0] len;
    logic [HDR_W-1:0] hdr_base;
    logic [HDR_W-1:0] ext_min;
    logic [HDR_W-1:0] hdr_full;
    logic [HDR_W-1:0] need;
    logic [HDR_W-1:0] plen;
    logic             pad;
    logic             ext;
    status_t          status;

    assign sum_pop  = !sum_empty && !res_full;
    assign res_push = sum_pop;

    assign pad      = sum.first_octet[5];
    assign ext      = sum.first_octet[4];
    assign len      = HDR_W'(sum.len);
    assign hdr_base = HDR_W'(FIXED_HDR) + HDR_W'({sum.first_octet[3:0], 2'b00});
    assign ext_min  = hdr_base + HDR_W'(EXT_HDR);
    // extension length is in 32-bit words
    assign hdr_full = ext ? ext_min + HDR_W'({sum.ext_words, 2'b00}) : hdr_base;
    assign need     = hdr_full + (pad ? HDR_W'(sum.pad_byte) : '0);
    assign plen     = len - need;

    always_comb
    begin
        if (sum.oversize)
        begin
            status = ST_OVERSIZE;
        end
        else if (len < HDR_W'(FIXED_HDR))
        begin
            status = ST_SHORT;
        end
        else if (ext && len < ext_min)
        begin
            status = ST_SHORT;
        end
        else if (len < need)
        begin
            status = ST_SHORT;
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign res.status            = status;
    assign res.version           = sum.first_octet[7:6];
    assign res.marker            = sum.second_octet[7];
    assign res.payload_type      = sum.second_octet[6:0];
    assign res.sequence_number   = sum.seq;
    assign res.timestamp         = sum.tstamp;
    assign res.ssrc              = sum.source;
    assign res.csrc_count        = sum.first_octet[3:0];
    assign res.extension_present = ext;
    assign res.extension_type    = ext ? sum.ext_type : '0;
    assign res.payload_offset    = (status == ST_OK) ? hdr_full[OUT_W-1:0] : '0;
    assign res.payload_length    = (status == ST_OK) ? plen[OUT_W-1:0] : '0;

`ifndef SYNTHESIS
    a_oversize_wins: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_pop && sum.oversize) |-> (res.status == ST_OVERSIZE))
        else $error("oversize packet not flagged");

    a_bad_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.status != ST_OK) |->
            (res.payload_offset == '0 && res.payload_length == '0))
        else $error("offset or length reported on failed packet");
`endif

endmodule

// ----- hdl/rtp_header_parse_check_unit.sv -----
// RTP receive header parser: takes one packet byte per cycle while full is low (network
// order, last byte flagged) and yields one result per packet with status, fixed-header
// fields, extension type, payload offset and payload length net of padding. Each packet's
// record, built by the capture front end, passes through the two-entry packet-record queue
// to the length checker, which drains one record per cycle into the result queue while that
// queue is not full. full rises only when the packet-record queue is backed up by a stalled result side.
module rtp_header_parse_check_unit #(
    parameter int MAX_PACKET_BYTES = rhpc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  rhpc_pkg::in_item_t in_item,
    output logic               empty,
    input  logic               pop,
    output rhpc_pkg::result_t  result
);

    import rhpc_pkg::*;

    logic     accept;
    logic     sum_push;
    summary_t sum_in;
    summary_t sum_out;
    logic     sum_empty;
    logic     sum_pop;
    logic     res_full;
    logic     res_push;
    result_t  res_in;

    assign accept = push && !full;

    rhpc_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_item  (in_item),
        .sum_push (sum_push),
        .sum      (sum_in)
    );

    rhpc_queue #(
        .WIDTH($bits(summary_t)),
        .DEPTH(SUM_DEPTH)
    ) u_sum_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sum_push),
        .wr_data (sum_in),
        .full    (full),
        .rd_en   (sum_pop),
        .rd_data (sum_out),
        .empty   (sum_empty)
    );

    rhpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum       (sum_out),
        .sum_empty (sum_empty),
        .sum_pop   (sum_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    rhpc_queue #(
        .WIDTH($bits(result_t)),
        .DEPTH(RES_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule
